// File: hw/rtl/sas_pkg.sv
// sas_pkg: shared types, constants and controller state encoding for the
// suffix array sorter. No dependencies.
package sas_pkg;
  localparam int MaxText = 64;
  localparam int AddrW   = 6;
  localparam int LenW    = 7;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_final;
  } in_word_t;

  typedef struct packed {
    logic [5:0] suffix_start;
    logic       run_end;
    logic       truncated;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_INIT, ST_OUTER, ST_LDCUR, ST_RDPREV, ST_CMPSET, ST_CMPRD, ST_CMPEVAL,
    ST_SHIFT, ST_PLACE, ST_EMITRD, ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // store in word
    logic init_wr;    // order[i] = i
    logic i_clr;
    logic i_inc;
    logic start_ins;  // cur = order[i] (read issued earlier), j = i
    logic rd_prev;    // read order[j-1]
    logic cmp_set;    // set compare pointers, k = 0
    logic cmp_rd;     // read text at p+k, q+k
    logic k_inc;
    logic shift;      // order[j] = prev, j--
    logic place;      // order[j] = cur
    logic rd_out;     // read order[i]
    logic emit;
    logic done;       // clear length and overflow
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic last_byte;  // accepted word is final
    logic i_at_end;   // i == n-1
    logic i_done;     // i >= n
    logic j_zero;
    logic span_end;   // k reached shorter length
    logic chars_ne;
    logic less;       // decision when chars differ or span ended
  } sts_t;
endpackage

// File: hw/rtl/sas_ctrl.sv
// sas_ctrl: controller state machine of the suffix array sorter.
// Depends on sas_pkg.
module sas_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sas_pkg::sts_t sts,
  output sas_pkg::ctl_t ctl
);
  sas_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sas_pkg::ST_LOAD;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    busy = (state_r != sas_pkg::ST_LOAD);
    unique case (state_r)
      sas_pkg::ST_LOAD: begin
        if (start) begin
          ctl.load = 1'b1;
          if (sts.last_byte) begin
            ctl.i_clr = 1'b1;
            state_nxt = sas_pkg::ST_INIT;
          end
        end
      end
      sas_pkg::ST_INIT: begin
        ctl.init_wr = 1'b1;
        ctl.i_inc = 1'b1;
        if (sts.i_at_end) state_nxt = sas_pkg::ST_OUTER;
      end
      sas_pkg::ST_OUTER: begin
        // i starts at 1 here after init pass wrapped; done when i >= n
        if (sts.i_done) begin
          ctl.i_clr = 1'b1;
          state_nxt = sas_pkg::ST_EMITRD;
        end else begin
          ctl.rd_out = 1'b1;
          state_nxt = sas_pkg::ST_LDCUR;
        end
      end
      sas_pkg::ST_LDCUR: begin
        ctl.start_ins = 1'b1;
        state_nxt = sas_pkg::ST_RDPREV;
      end
      sas_pkg::ST_RDPREV: begin
        if (sts.j_zero) begin
          state_nxt = sas_pkg::ST_PLACE;
        end else begin
          ctl.rd_prev = 1'b1;
          state_nxt = sas_pkg::ST_CMPSET;
        end
      end
      sas_pkg::ST_CMPSET: begin
        ctl.cmp_set = 1'b1;
        state_nxt = sas_pkg::ST_CMPRD;
      end
      sas_pkg::ST_CMPRD: begin
        ctl.cmp_rd = 1'b1;
        state_nxt = sas_pkg::ST_CMPEVAL;
      end
      sas_pkg::ST_CMPEVAL: begin
        if (sts.span_end || sts.chars_ne) begin
          state_nxt = sts.less ? sas_pkg::ST_SHIFT : sas_pkg::ST_PLACE;
        end else begin
          ctl.k_inc = 1'b1;
          state_nxt = sas_pkg::ST_CMPRD;
        end
      end
      sas_pkg::ST_SHIFT: begin
        ctl.shift = 1'b1;
        state_nxt = sas_pkg::ST_RDPREV;
      end
      sas_pkg::ST_PLACE: begin
        ctl.place = 1'b1;
        ctl.i_inc = 1'b1;
        state_nxt = sas_pkg::ST_OUTER;
      end
      sas_pkg::ST_EMITRD: begin
        ctl.rd_out = 1'b1;
        state_nxt = sas_pkg::ST_EMIT;
      end
      sas_pkg::ST_EMIT: begin
        ctl.emit = 1'b1;
        ctl.i_inc = 1'b1;
        if (sts.i_at_end) begin
          ctl.done = 1'b1;
          state_nxt = sas_pkg::ST_LOAD;
        end else begin
          state_nxt = sas_pkg::ST_EMITRD;
        end
      end
      default: state_nxt = sas_pkg::ST_LOAD;
    endcase
  end
endmodule

// File: hw/rtl/sas_datapath.sv
// sas_datapath: text and order memories, index counters and the suffix
// comparator of the suffix array sorter. Depends on sas_pkg.
module sas_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               signed_chars,
  input  sas_pkg::in_word_t  in_word,
  input  sas_pkg::ctl_t      ctl,
  output sas_pkg::sts_t      sts,
  output logic               out_valid,
  output sas_pkg::out_word_t out_word
);
  logic [7:0] text_mem [sas_pkg::MaxText];
  logic [5:0] order_mem [sas_pkg::MaxText];

  logic [sas_pkg::LenW-1:0] len_r;
  logic                     ovf_r;
  logic [sas_pkg::LenW-1:0] i_r;
  logic [sas_pkg::AddrW-1:0] j_r, cur_r, prev_r, ord_rd_r, k_r, p_r, q_r;
  logic [sas_pkg::LenW-1:0] span_r;
  logic [7:0] x_r, y_r;
  logic       p_short_r;
  logic       out_valid_r;
  logic [sas_pkg::AddrW-1:0] ord_addr;

  // Order memory single read port address.
  always_comb begin
    ord_addr = i_r[sas_pkg::AddrW-1:0];
    if (ctl.rd_prev) ord_addr = j_r - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (ctl.load && len_r < sas_pkg::LenW'(sas_pkg::MaxText))
      text_mem[len_r[sas_pkg::AddrW-1:0]] <= in_word.text_byte;
    if (ctl.cmp_rd) begin
      x_r <= text_mem[6'(p_r + k_r)];
      y_r <= text_mem[6'(q_r + k_r)];
    end
    if (ctl.init_wr) order_mem[i_r[sas_pkg::AddrW-1:0]] <= i_r[sas_pkg::AddrW-1:0];
    else if (ctl.shift) order_mem[j_r] <= prev_r;
    else if (ctl.place) order_mem[j_r] <= cur_r;
    if (ctl.rd_out || ctl.rd_prev) ord_rd_r <= order_mem[ord_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      i_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
      if (ctl.done) begin
        len_r <= '0;
        ovf_r <= 1'b0;
      end else if (ctl.load) begin
        if (len_r < sas_pkg::LenW'(sas_pkg::MaxText)) len_r <= len_r + 7'd1;
        else ovf_r <= 1'b1;
      end
      if (ctl.i_clr) i_r <= '0;
      else if (ctl.init_wr && i_r == len_r - 7'd1) i_r <= 7'd1;
      else if (ctl.i_inc) i_r <= i_r + 7'd1;
    end
  end

  // Insertion step registers.
  logic [sas_pkg::LenW-1:0] len_p, len_q;
  assign len_p = len_r - {1'b0, cur_r};
  assign len_q = len_r - {1'b0, ord_rd_r};

  always_ff @(posedge clk) begin
    if (ctl.start_ins) begin
      cur_r <= ord_rd_r;
      j_r <= i_r[sas_pkg::AddrW-1:0];
    end
    if (ctl.shift) j_r <= j_r - 6'd1;
    if (ctl.cmp_set) begin
      prev_r <= ord_rd_r;
      p_r <= cur_r;
    end
    if (ctl.k_inc) k_r <= k_r + 6'd1;
    else if (ctl.cmp_set) k_r <= '0;
  end

  // q and span come from order[j-1] as it is read back
  always_ff @(posedge clk) begin
    if (ctl.cmp_set) begin
      q_r <= ord_rd_r;
      p_short_r <= len_p < len_q;
      span_r <= (len_p < len_q) ? len_p : len_q;
    end
  end

  // Pointers p/q: drive reads in CMPRD using current values.
  logic [7:0] kx, ky;
  assign kx = signed_chars ? (x_r ^ 8'h80) : x_r;
  assign ky = signed_chars ? (y_r ^ 8'h80) : y_r;

  assign sts.last_byte = in_word.is_final;
  assign sts.i_at_end  = (i_r == len_r - 7'd1);
  assign sts.i_done    = (i_r >= len_r);
  assign sts.j_zero    = (j_r == '0);
  assign sts.span_end  = ({1'b0, k_r} >= span_r);
  assign sts.chars_ne  = (kx != ky);
  assign sts.less      = sts.span_end ? p_short_r : (kx < ky);

  assign out_valid = out_valid_r;
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_word.suffix_start <= ord_rd_r;
      out_word.run_end <= sts.i_at_end;
      out_word.truncated <= ovf_r;
    end
  end
endmodule

// File: hw/rtl/suffix_array_sorter.sv
// suffix_array_sorter: top level, joins controller and datapath.
// Depends on sas_pkg, sas_ctrl, sas_datapath.
//
// Usage: drive in_word and pulse start while busy is low; each such cycle
// takes one text byte. Up to 64 bytes are kept; further ones are dropped
// and flag the results as truncated. A word with is_final closes the block
// and busy rises while the suffixes are sorted by insertion sort.
// After the final word the order is seeded; each insertion step then loads
// the next suffix, compares it with its predecessor one character at a time,
// shifts that predecessor up while the new suffix sorts first, and places it.
// Results come out on out_word with out_valid high for one cycle each;
// run_end marks the last. The receiver cannot stall.
// busy falls as the last result appears; the next block may then be loaded.
// cfg_we with cfg_wdata sets signed_chars (reset 1), written while idle.
// Reset (rst_n low, synchronous) empties the block and returns to loading.
// Memories need no clearing; entries are written before they are read.
module suffix_array_sorter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sas_pkg::in_word_t  in_word,
  output logic               out_valid,
  output sas_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  logic          signed_chars_r;
  sas_pkg::ctl_t ctl;
  sas_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) signed_chars_r <= 1'b1;
    else if (cfg_we) signed_chars_r <= cfg_wdata;
  end

  sas_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
  );

  sas_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .signed_chars(signed_chars_r), .in_word(in_word),
    .ctl(ctl), .sts(sts), .out_valid(out_valid), .out_word(out_word)
  );
endmodule

// File: tb/sv/tb_suffix_array_sorter.sv
// Testbench for suffix_array_sorter: loads text blocks word by word, predicts
// the sorted suffix order of each block and checks every result word.
// Depends on sas_pkg and the suffix_array_sorter RTL.
module tb_suffix_array_sorter;
  localparam int WatchdogLimit = 1000000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  sas_pkg::in_word_t  in_word;
  logic               out_valid;
  sas_pkg::out_word_t out_word;
  logic               cfg_we;
  logic               cfg_wdata;

  suffix_array_sorter uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Predictor state: our own copy of the block and the register.
  logic [7:0]         blk_text [sas_pkg::MaxText];
  int                 blk_len;
  bit                 blk_overflow;
  bit                 cmp_signed;
  sas_pkg::out_word_t rank_queue [$];

  int mismatches;
  int results_seen;
  int blocks_sent;
  int idle_cycles;
  bit accepted_now;
  int burst_left;

  // Signed order equals unsigned order with the sign bit flipped.
  function automatic logic [7:0] order_key(logic [7:0] c);
    return cmp_signed ? (c ^ 8'h80) : c;
  endfunction

  function automatic bit suffix_before(int p, int q);
    int span;
    span = (blk_len - p) < (blk_len - q) ? (blk_len - p) : (blk_len - q);
    for (int i = 0; i < span; i++) begin
      if (order_key(blk_text[p+i]) != order_key(blk_text[q+i]))
        return order_key(blk_text[p+i]) < order_key(blk_text[q+i]);
    end
    return (blk_len - p) < (blk_len - q);
  endfunction

  // Apply one accepted word; a final word pushes the whole sorted run.
  task automatic predict_word(sas_pkg::in_word_t w);
    int order [sas_pkg::MaxText];
    int cur, j;
    sas_pkg::out_word_t r;
    if (blk_len < sas_pkg::MaxText) begin
      blk_text[blk_len] = w.text_byte;
      blk_len++;
    end else begin
      blk_overflow = 1'b1;
    end
    if (w.is_final) begin
      for (int i = 0; i < blk_len; i++) order[i] = i;
      for (int i = 1; i < blk_len; i++) begin
        cur = order[i];
        j = i;
        while (j > 0 && suffix_before(cur, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = cur;
      end
      for (int k = 0; k < blk_len; k++) begin
        r.suffix_start = order[k][5:0];
        r.run_end      = (k == blk_len - 1);
        r.truncated    = blk_overflow;
        rank_queue.push_back(r);
      end
      blk_len = 0;
      blk_overflow = 1'b0;
      blocks_sent++;
    end
  endtask

  // Result checker: the receiver cannot stall, so every strobe is a result.
  always @(posedge clk) begin
    accepted_now = 1'b0;
    if (rst_n && out_valid) begin
      accepted_now = 1'b1;
      results_seen++;
      if (rank_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", out_word);
      end else begin
        sas_pkg::out_word_t e;
        e = rank_queue.pop_front();
        if (out_word !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: rank word exp start=%0d end=%0d trunc=%0d got %0d %0d %0d",
                     e.suffix_start, e.run_end, e.truncated,
                     out_word.suffix_start, out_word.run_end, out_word.truncated);
        end
      end
    end
    if (rst_n && start && !busy) accepted_now = 1'b1;
    idle_cycles = accepted_now ? 0 : idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Send one word; bursts of back-to-back words with random gaps between.
  task automatic send_word(logic [7:0] b, bit fin);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    burst_left--;
    in_word.text_byte = b;
    in_word.is_final = fin;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predict_word(in_word);
    @(negedge clk);
    start = 1'b0;
    // a final word raises busy; wait until the run has drained
    if (fin) while (busy || rank_queue.size() != 0) @(negedge clk);
  endtask

  task automatic send_block(int len, int alpha);
    for (int i = 0; i < len; i++)
      send_word(alpha == 0 ? 8'($urandom) : 8'($urandom_range(0, alpha)),
                i == len - 1);
  endtask

  // Block is idle here: all results are back and busy is low.
  task automatic write_signed(bit v);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cmp_signed = v;
  endtask

  task automatic test_directed();
    send_word(8'h41, 1'b1);                       // single byte
    send_word(8'h00, 1'b0); send_word(8'h00, 1'b1); // repeat: prefix rule
    send_word(8'hFF, 1'b0); send_word(8'h80, 1'b0);
    send_word(8'h7F, 1'b0); send_word(8'h01, 1'b1); // sign-sensitive, signed
    write_signed(1'b0);
    send_word(8'hFF, 1'b0); send_word(8'h80, 1'b0);
    send_word(8'h7F, 1'b0); send_word(8'h01, 1'b1);
    for (int i = 0; i < 4; i++) send_word(8'h55, i == 3);
  endtask

  task automatic test_full_and_overflow();
    send_block(sas_pkg::MaxText, 1);                 // exactly full
    for (int i = 0; i < sas_pkg::MaxText + 3; i++)   // final word dropped too
      send_word(8'($urandom), i == sas_pkg::MaxText + 2);
  endtask

  task automatic test_random();
    int mode;
    for (int n = 0; n < 12; n++) begin
      mode = $urandom_range(0, 3);
      if (n == 4) write_signed(1'b1);
      if (n == 8) write_signed(1'b0);
      send_block($urandom_range(1, 10), mode == 0 ? 0 : (mode == 1 ? 1 : 3));
    end
    send_block(sas_pkg::MaxText, 0);
  endtask

  initial begin
    rst_n = 1'b0; start = 1'b0; in_word = '0; cfg_we = 1'b0; cfg_wdata = 1'b0;
    blk_len = 0; blk_overflow = 1'b0; cmp_signed = 1'b1;
    mismatches = 0; results_seen = 0; blocks_sent = 0; idle_cycles = 0;
    burst_left = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_full_and_overflow();
    test_random();
    repeat (20) @(negedge clk);
    $display("Covered %0d blocks, %0d rank words, both byte orders, overflow.",
             blocks_sent, results_seen);
    if (mismatches == 0 && rank_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
